@@ rtl/lvs3_pkg.sv @@
// shared types and constants for the 3d line voxel sampler
// no dependencies; imported by line_voxel_sampler_3d_core
`default_nettype none

package lvs3_pkg;

  // cell index width and fraction bits of the fixed point length
  localparam int COORD_BITS    = 5;
  localparam int LEN_FRAC_BITS = 8;

  // derived widths: sum of three squares, radicand, length, sample index
  localparam int SUM_W  = 2 * COORD_BITS + 2;
  localparam int RAD_W  = SUM_W + 2 * LEN_FRAC_BITS;
  localparam int LEN_W  = RAD_W / 2;
  localparam int CNT_W  = COORD_BITS + 1;
  localparam int AXES   = 3;
  localparam int AXIS_W = 2;

  localparam logic [AXIS_W-1:0] AXIS_LAST = AXIS_W'(AXES - 1);

  typedef logic [COORD_BITS-1:0] coord_t;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_SQUARE,
    ST_ROOT,
    ST_CHECK,
    ST_STEP,
    ST_FINISH
  } state_t;

endpackage

`default_nettype wire

@@ rtl/line_voxel_sampler_3d_core.sv @@
// 3d line voxel sampler: walks the sampled line between two cells
// depends on lvs3_pkg
`default_nettype none

// Usage
//   Input channel (in_valid / in_ready) takes one item: a start cell and an
//   end cell. Output channel (out_valid / out_ready) gives the voxels of the
//   line in order from start to end, one per item, last_voxel set on the
//   final one. A zero-length line gives the end cell alone.
//   One compare-subtract unit does the integer square root for the Q.8
//   length, then per sample, after a check step, advances the quotient of
//   each axis in turn; the squares and sample cells use separate logic.
//   in_ready is high only while the block is idle.
//   The newest voxel waits in a hold register until the next one is known,
//   so the last flag can be set; a stalled receiver only holds the sequencer
//   at the point where a voxel is moved to the output register.
//   Reset (rst, synchronous) returns to idle and drops any pending voxels.
module line_voxel_sampler_3d_core (
  input  wire               clk,
  input  wire               rst,
  input  wire               in_valid,
  output logic              in_ready,
  input  lvs3_pkg::coord_t  start_x,
  input  lvs3_pkg::coord_t  start_y,
  input  lvs3_pkg::coord_t  start_z,
  input  lvs3_pkg::coord_t  end_x,
  input  lvs3_pkg::coord_t  end_y,
  input  lvs3_pkg::coord_t  end_z,
  output logic              out_valid,
  input  wire               out_ready,
  output lvs3_pkg::coord_t  voxel_x,
  output lvs3_pkg::coord_t  voxel_y,
  output lvs3_pkg::coord_t  voxel_z,
  output logic              last_voxel
);
  import lvs3_pkg::*;

  state_t state, state_next;

  coord_t in_s [AXES];
  coord_t in_e [AXES];
  coord_t s_pt [AXES];
  coord_t e_pt [AXES];
  coord_t mag  [AXES];
  logic   neg  [AXES];
  coord_t q    [AXES];
  logic [LEN_W-1:0] r [AXES];
  coord_t hold [AXES];
  coord_t cur  [AXES];
  logic [2*COORD_BITS-1:0] sq [AXES];
  logic hold_valid;

  logic [RAD_W-1:0] v, res, bit_r;
  logic [LEN_W-1:0] len;
  logic [CNT_W-1:0] idx;
  logic [AXIS_W-1:0] axis;

  logic [RAD_W-1:0] opa, opb;
  logic [RAD_W:0]   diff;
  logic             ge;

  logic accept, out_free, sample, same, hold_is_end;
  logic emit, emit_last, load_cur, load_end, hold_clear;

  assign accept   = in_valid && in_ready;
  assign out_free = !out_valid || out_ready;
  assign len      = res[LEN_W-1:0];

  // input unpacking
  assign in_s[0] = start_x;
  assign in_s[1] = start_y;
  assign in_s[2] = start_z;
  assign in_e[0] = end_x;
  assign in_e[1] = end_y;
  assign in_e[2] = end_z;

  // per axis squares, current sample and compares
  always_comb begin
    same        = hold_valid;
    hold_is_end = hold_valid;
    for (int a = 0; a < AXES; a++) begin
      sq[a] = {{COORD_BITS{1'b0}}, mag[a]} * {{COORD_BITS{1'b0}}, mag[a]};
      if (neg[a]) begin
        cur[a] = s_pt[a] - q[a] - COORD_BITS'(r[a] != '0);
      end else begin
        cur[a] = s_pt[a] + q[a];
      end
      if (cur[a] != hold[a]) same = 1'b0;
      if (e_pt[a] != hold[a]) hold_is_end = 1'b0;
    end
  end

  assign sample = {idx, {LEN_FRAC_BITS{1'b0}}} < len;

  // shared compare-subtract unit
  always_comb begin
    case (state)
      ST_ROOT: begin
        opa = v;
        opb = res + bit_r;
      end
      ST_STEP: begin
        opa = RAD_W'(r[axis]) + RAD_W'({mag[axis], {LEN_FRAC_BITS{1'b0}}});
        opb = RAD_W'(len);
      end
      default: begin
        opa = '0;
        opb = '0;
      end
    endcase
    diff = {1'b0, opa} - {1'b0, opb};
    ge   = !diff[RAD_W];
  end

  // sequencer next state and strobes
  always_comb begin
    state_next = state;
    in_ready   = (state == ST_IDLE);
    emit       = 1'b0;
    emit_last  = 1'b0;
    load_cur   = 1'b0;
    load_end   = 1'b0;
    hold_clear = 1'b0;
    case (state)
      ST_IDLE: begin
        if (in_valid) state_next = ST_SQUARE;
      end
      ST_SQUARE: begin
        state_next = ST_ROOT;
      end
      ST_ROOT: begin
        if (bit_r[0]) state_next = ST_CHECK;
      end
      ST_CHECK: begin
        if (!sample) begin
          state_next = ST_FINISH;
        end else if (same) begin
          state_next = ST_STEP;
        end else if (!hold_valid || out_free) begin
          emit       = hold_valid;
          load_cur   = 1'b1;
          state_next = ST_STEP;
        end
      end
      ST_STEP: begin
        if (axis == AXIS_LAST) state_next = ST_CHECK;
      end
      ST_FINISH: begin
        if (hold_is_end) begin
          if (out_free) begin
            emit       = 1'b1;
            emit_last  = 1'b1;
            hold_clear = 1'b1;
            state_next = ST_IDLE;
          end
        end else if (!hold_valid || out_free) begin
          emit     = hold_valid;
          load_end = 1'b1;
        end
      end
      default: begin
        state_next = ST_IDLE;
      end
    endcase
  end

  // control registers
  always_ff @(posedge clk) begin
    if (rst) begin
      state      <= ST_IDLE;
      out_valid  <= 1'b0;
      hold_valid <= 1'b0;
    end else begin
      state <= state_next;
      if (emit) begin
        out_valid <= 1'b1;
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end
      if (load_cur || load_end) begin
        hold_valid <= 1'b1;
      end else if (hold_clear) begin
        hold_valid <= 1'b0;
      end
    end
  end

  // datapath registers
  always_ff @(posedge clk) begin
    // capture the endpoints and axis deltas
    if (accept) begin
      for (int a = 0; a < AXES; a++) begin
        s_pt[a] <= in_s[a];
        e_pt[a] <= in_e[a];
        neg[a]  <= in_e[a] < in_s[a];
        mag[a]  <= (in_e[a] < in_s[a]) ? in_s[a] - in_e[a] : in_e[a] - in_s[a];
      end
    end

    // squared length and walk counters
    if (state == ST_SQUARE) begin
      v     <= {SUM_W'(sq[0]) + SUM_W'(sq[1]) + SUM_W'(sq[2]),
                {(2 * LEN_FRAC_BITS){1'b0}}};
      res   <= '0;
      bit_r <= RAD_W'(1) << (RAD_W - 2);
      idx   <= '0;
      axis  <= '0;
      for (int a = 0; a < AXES; a++) begin
        q[a] <= '0;
        r[a] <= '0;
      end
    end

    // one digit of the square root
    if (state == ST_ROOT) begin
      if (ge) begin
        v   <= diff[RAD_W-1:0];
        res <= (res >> 1) + bit_r;
      end else begin
        res <= res >> 1;
      end
      bit_r <= bit_r >> 2;
    end

    // advance quotient and remainder of one axis
    if (state == ST_STEP) begin
      if (ge) begin
        r[axis] <= diff[LEN_W-1:0];
        q[axis] <= q[axis] + COORD_BITS'(1);
      end else begin
        r[axis] <= opa[LEN_W-1:0];
      end
      if (axis == AXIS_LAST) begin
        axis <= '0;
        idx  <= idx + CNT_W'(1);
      end else begin
        axis <= axis + AXIS_W'(1);
      end
    end

    // output register fed from the hold register
    if (emit) begin
      voxel_x    <= hold[0];
      voxel_y    <= hold[1];
      voxel_z    <= hold[2];
      last_voxel <= emit_last;
    end

    // hold register takes the newest voxel
    if (load_cur) begin
      for (int a = 0; a < AXES; a++) hold[a] <= cur[a];
    end else if (load_end) begin
      for (int a = 0; a < AXES; a++) hold[a] <= e_pt[a];
    end
  end

endmodule

`default_nettype wire
